@@ rtl/ppp_pkg.sv @@
// Shared types and constants for the perspective point projector.
package ppp_pkg;

   typedef enum logic [1:0] {
      FUNC_LOAD_WORLD = 2'd0,
      FUNC_LOAD_PROJ  = 2'd1,
      FUNC_PROJECT    = 2'd2,
      FUNC_NONE       = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      OUTCOME_OK         = 2'd0,
      OUTCOME_NOT_LOADED = 2'd1,
      OUTCOME_BEHIND     = 2'd2,
      OUTCOME_OUTSIDE    = 2'd3
   } outcome_type;

   localparam logic [1:0] CSR_LEFT   = 2'd0;
   localparam logic [1:0] CSR_TOP    = 2'd1;
   localparam logic [1:0] CSR_RIGHT  = 2'd2;
   localparam logic [1:0] CSR_BOTTOM = 2'd3;

endpackage

@@ rtl/ppp_matvec.sv @@
// Pipelined 4x4 matrix by vector transform with registered products and sums.
module ppp_matvec #(
   parameter int FRAC_BITS = 16,
   parameter int IN_W = 32,
   parameter int OUT_W = 40,
   parameter int TAG_W = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic in_valid,
   input  logic [TAG_W-1:0] in_tag,
   input  logic signed [IN_W-1:0] vec_0,
   input  logic signed [IN_W-1:0] vec_1,
   input  logic signed [IN_W-1:0] vec_2,
   input  logic signed [IN_W-1:0] vec_3,
   input  logic [16*32-1:0] mat,
   output logic out_valid,
   output logic [TAG_W-1:0] out_tag,
   output logic signed [OUT_W-1:0] res_0,
   output logic signed [OUT_W-1:0] res_1,
   output logic signed [OUT_W-1:0] res_2,
   output logic signed [OUT_W-1:0] res_3
);
   localparam int PW = IN_W + 32;

   logic signed [PW-1:0] prod_ff [16];
   logic signed [PW-1:0] prod_in [16];
   logic signed [OUT_W-1:0] sum_in [4];
   logic signed [OUT_W-1:0] sum_ff [4];
   logic [1:0] valid_ff;
   logic [TAG_W-1:0] tag_ff [2];

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            logic signed [IN_W-1:0] v;
            v = (c == 0) ? vec_0 : (c == 1) ? vec_1 : (c == 2) ? vec_2 : vec_3;
            prod_in[c*4+r] = PW'(v) * PW'($signed(mat[(c*4+r)*32 +: 32]));
         end
      end
      for (int r = 0; r < 4; r++) begin
         sum_in[r] = OUT_W'(prod_ff[r] >>> FRAC_BITS) + OUT_W'(prod_ff[4+r] >>> FRAC_BITS)
                   + OUT_W'(prod_ff[8+r] >>> FRAC_BITS) + OUT_W'(prod_ff[12+r] >>> FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[0], in_valid};
      end
      if (advance) begin
         prod_ff <= prod_in;
         sum_ff <= sum_in;
         tag_ff[0] <= in_tag;
         tag_ff[1] <= tag_ff[0];
      end
   end

   assign out_valid = valid_ff[1];
   assign out_tag = tag_ff[1];
   assign res_0 = sum_ff[0];
   assign res_1 = sum_ff[1];
   assign res_2 = sum_ff[2];
   assign res_3 = sum_ff[3];
endmodule

@@ rtl/ppp_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module ppp_divider #(
   parameter int NUM_W = 66,
   parameter int DEN_W = 33,
   parameter int TAG_W = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic in_valid,
   input  logic [TAG_W-1:0] in_tag,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic out_valid,
   output logic [TAG_W-1:0] out_tag,
   output logic [NUM_W-1:0] quo
);
   logic [NUM_W:0] valid_ff;
   logic [TAG_W-1:0] tag_ff [NUM_W+1];
   logic [NUM_W-1:0] q_ff [NUM_W+1];
   logic [DEN_W:0] r_ff [NUM_W+1];
   logic [DEN_W-1:0] d_ff [NUM_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[NUM_W-1:0], in_valid};
      end
      if (advance) begin
         q_ff[0] <= num;
         r_ff[0] <= '0;
         d_ff[0] <= den;
         tag_ff[0] <= in_tag;
         for (int s = 0; s < NUM_W; s++) begin
            logic [DEN_W:0] t;
            t = {r_ff[s][DEN_W-1:0], q_ff[s][NUM_W-1]};
            if (t >= {1'b0, d_ff[s]}) begin
               r_ff[s+1] <= t - {1'b0, d_ff[s]};
               q_ff[s+1] <= {q_ff[s][NUM_W-2:0], 1'b1};
            end else begin
               r_ff[s+1] <= t;
               q_ff[s+1] <= {q_ff[s][NUM_W-2:0], 1'b0};
            end
            d_ff[s+1] <= d_ff[s];
            tag_ff[s+1] <= tag_ff[s];
         end
      end
   end

   assign out_valid = valid_ff[NUM_W];
   assign out_tag = tag_ff[NUM_W];
   assign quo = q_ff[NUM_W];
endmodule

@@ rtl/perspective_point_projector_unit.sv @@
// Top level of the perspective point projector.
// Requests pass through the two transforms, the test and scaling registers, the
// dividers and an output register, in that order, on the way to the result.
// Throughput: one request per cycle; a stall on the result freezes the whole pipeline.
// Reset clears loaded masks, valid bits and screen bounds (0, 1080, 1920, 0).
module perspective_point_projector_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_func,
   input  logic [3:0] req_elem_index,
   input  logic signed [31:0] req_elem_value,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_visible,
   output ppp_pkg::outcome_type rsp_outcome,
   output logic signed [15:0] rsp_pixel_x,
   output logic signed [15:0] rsp_pixel_y,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_data
);
   import ppp_pkg::*;

   localparam int EW = 64;
   localparam int CW = 72;
   localparam int NW = 66;
   localparam int DW = 33;

   logic advance;
   logic [15:0] wmask_ff, pmask_ff;
   logic [16*32-1:0] wmat_ff, pmat_ff;
   logic signed [15:0] left_ff, top_ff, right_ff, bottom_ff;
   logic accept, proj, loaded;
   logic [1:0] pl_v_ff;
   logic [3:0] pl_idx_ff [2];
   logic [31:0] pl_val_ff [2];

   assign advance = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;
   assign accept = req_valid && advance;
   assign loaded = (wmask_ff == 16'hFFFF) && (pmask_ff == 16'hFFFF);
   assign proj = accept && (func_type'(req_func) == FUNC_PROJECT);

   // Projection loads reach the matrix when they line up with the second transform.
   always_ff @(posedge clock) begin
      if (reset) begin
         wmask_ff <= '0;
         pmask_ff <= '0;
         pl_v_ff <= '0;
         left_ff <= 16'sd0;
         top_ff <= 16'sd1080;
         right_ff <= 16'sd1920;
         bottom_ff <= 16'sd0;
      end else begin
         if (accept && func_type'(req_func) == FUNC_LOAD_WORLD)
            wmask_ff[req_elem_index] <= 1'b1;
         if (accept && func_type'(req_func) == FUNC_LOAD_PROJ)
            pmask_ff[req_elem_index] <= 1'b1;
         if (advance)
            pl_v_ff <= {pl_v_ff[0], accept && func_type'(req_func) == FUNC_LOAD_PROJ};
         if (csr_valid) begin
            case (csr_index)
               CSR_LEFT: left_ff <= csr_data;
               CSR_TOP: top_ff <= csr_data;
               CSR_RIGHT: right_ff <= csr_data;
               CSR_BOTTOM: bottom_ff <= csr_data;
               default: ;
            endcase
         end
      end
      if (accept && func_type'(req_func) == FUNC_LOAD_WORLD)
         wmat_ff[req_elem_index*32 +: 32] <= req_elem_value;
      if (advance) begin
         pl_idx_ff[0] <= req_elem_index;
         pl_idx_ff[1] <= pl_idx_ff[0];
         pl_val_ff[0] <= req_elem_value;
         pl_val_ff[1] <= pl_val_ff[0];
      end
      if (advance && pl_v_ff[1])
         pmat_ff[pl_idx_ff[1]*32 +: 32] <= pl_val_ff[1];
   end

   // World transform.
   logic ev;
   logic [0:0] etag;
   logic signed [EW-1:0] e0, e1, e2, e3;
   ppp_matvec #(.FRAC_BITS(FRAC_BITS), .IN_W(32), .OUT_W(EW), .TAG_W(1)) u_world (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(proj), .in_tag(loaded),
      .vec_0(req_point_x), .vec_1(req_point_y), .vec_2(req_point_z),
      .vec_3(32'sd1 <<< FRAC_BITS), .mat(wmat_ff), .out_valid(ev), .out_tag(etag),
      .res_0(e0), .res_1(e1), .res_2(e2), .res_3(e3));

   function automatic logic signed [31:0] sat32(input logic signed [EW-1:0] v);
      if (v > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFFFFFF;
      if (v < -64'sh0000_0000_8000_0000) return 32'sh80000000;
      return v[31:0];
   endfunction

   logic cv;
   logic [0:0] ctag;
   logic signed [CW-1:0] x, y, z, w;
   ppp_matvec #(.FRAC_BITS(FRAC_BITS), .IN_W(32), .OUT_W(CW), .TAG_W(1)) u_proj (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(ev), .in_tag(etag),
      .vec_0(sat32(e0)), .vec_1(sat32(e1)), .vec_2(sat32(e2)), .vec_3(sat32(e3)),
      .mat(pmat_ff), .out_valid(cv), .out_tag(ctag),
      .res_0(x), .res_1(y), .res_2(z), .res_3(w));

   // Visibility tests and normalization.
   logic t_v_ff, t_ok_ff;
   outcome_type t_oc_ff;
   logic signed [CW-1:0] t_x_ff, t_y_ff, t_w_ff;
   outcome_type oc_in;
   logic [5:0] sh;
   always_comb begin
      logic signed [CW+11:0] w23, x20, y20;
      w23 = (CW+12)'(w) * 23;
      x20 = (CW+12)'(x) * 20;
      y20 = (CW+12)'(y) * 20;
      if (!ctag[0]) oc_in = OUTCOME_NOT_LOADED;
      else if (w <= 0 || (CW+12)'(w) * 1000 <= ((CW+12)'(1) <<< FRAC_BITS))
         oc_in = OUTCOME_BEHIND;
      else if (x20 < -w23 || x20 > w23 || y20 < -w23 || y20 > w23 || z < -w || z > w)
         oc_in = OUTCOME_OUTSIDE;
      else oc_in = OUTCOME_OK;
      sh = '0;
      for (int b = 31; b < CW - 1; b++)
         if (w[b]) sh = 6'(b - 30);
   end

   always_ff @(posedge clock) begin
      if (reset) t_v_ff <= 1'b0;
      else if (advance) t_v_ff <= cv;
      if (advance) begin
         t_oc_ff <= oc_in;
         t_x_ff <= x >>> sh;
         t_y_ff <= y >>> sh;
         t_w_ff <= w >>> sh;
      end
   end

   // Numerator and sign setup for the two divisions.
   logic s_v_ff;
   outcome_type s_oc_ff;
   logic [NW-1:0] nx_ff, ny_ff;
   logic negx_ff, negy_ff;
   logic [DW-1:0] d_ff;
   logic signed [NW-1:0] nx_in, ny_in;
   logic signed [33:0] sx, sy;
   logic signed [16:0] dx, dy;
   logic signed [50:0] mx, my;
   always_comb begin
      sx = 34'(t_x_ff + t_w_ff);
      sy = 34'(t_y_ff + t_w_ff);
      dx = 17'(right_ff) - 17'(left_ff);
      dy = 17'(top_ff) - 17'(bottom_ff);
      mx = 51'(sx) * 51'(dx);
      my = 51'(sy) * 51'(dy);
      nx_in = NW'(mx);
      ny_in = NW'(my);
   end
   always_ff @(posedge clock) begin
      if (reset) s_v_ff <= 1'b0;
      else if (advance) s_v_ff <= t_v_ff;
      if (advance) begin
         s_oc_ff <= t_oc_ff;
         negx_ff <= nx_in[NW-1];
         negy_ff <= ny_in[NW-1];
         nx_ff <= nx_in[NW-1] ? NW'(-nx_in) : NW'(nx_in);
         ny_ff <= ny_in[NW-1] ? NW'(-ny_in) : NW'(ny_in);
         d_ff <= DW'(t_w_ff) << 1;
      end
   end

   logic dxv, dyv;
   logic [3:0] dtag, dtag_y;
   logic [NW-1:0] qx, qy;
   ppp_divider #(.NUM_W(NW), .DEN_W(DW), .TAG_W(4)) u_divx (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(s_v_ff),
      .in_tag({s_oc_ff, negx_ff, negy_ff}), .num(nx_ff), .den(d_ff),
      .out_valid(dxv), .out_tag(dtag), .quo(qx));
   ppp_divider #(.NUM_W(NW), .DEN_W(DW), .TAG_W(4)) u_divy (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(s_v_ff),
      .in_tag({s_oc_ff, negx_ff, negy_ff}), .num(ny_ff), .den(d_ff),
      .out_valid(dyv), .out_tag(dtag_y), .quo(qy));

   function automatic logic signed [15:0] sat16(input logic signed [NW+1:0] v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   logic o_v_ff;
   outcome_type o_oc_ff;
   logic signed [15:0] o_px_ff, o_py_ff;
   logic signed [NW+1:0] fx, fy;
   always_comb begin
      fx = (NW+2)'(left_ff) + (dtag[1] ? -$signed({2'b0, qx}) : $signed({2'b0, qx}));
      fy = (NW+2)'(bottom_ff) + (dtag[0] ? -$signed({2'b0, qy}) : $signed({2'b0, qy}));
   end
   always_ff @(posedge clock) begin
      if (reset) o_v_ff <= 1'b0;
      else if (advance) o_v_ff <= dxv;
      if (advance) begin
         o_oc_ff <= outcome_type'(dtag[3:2]);
         o_px_ff <= (outcome_type'(dtag[3:2]) == OUTCOME_OK) ? sat16(fx) : 16'sd0;
         o_py_ff <= (outcome_type'(dtag[3:2]) == OUTCOME_OK) ? sat16(fy) : 16'sd0;
      end
   end

   assign rsp_valid = o_v_ff;
   assign rsp_outcome = o_oc_ff;
   assign rsp_visible = (o_oc_ff == OUTCOME_OK);
   assign rsp_pixel_x = o_px_ff;
   assign rsp_pixel_y = o_py_ff;

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      dxv == dyv && (!dxv || dtag[3:2] == dtag_y[3:2]))
      else $error("divider lanes out of step");
   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_visible |-> rsp_pixel_x == 0 && rsp_pixel_y == 0)
      else $error("hidden point has nonzero pixels");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_x))
      else $error("stalled result changed");
endmodule
